@@ hw/rtl/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared constants for the segment allocator and its checker.
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int SEGMENTS_DEF = 256;

	localparam int IDX_W    = 8;
	localparam int CNT_W    = 9;
	localparam int STATUS_W = 2;
	localparam int START_W  = 8;

	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = 16;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

endpackage

@@ hw/rtl/bra_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bra_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/bitmap_run_allocator.sv @@
// The allocator keeps one free bit per segment in a single-port-read memory
// and handles one request at a time. After reset a clearing pass marks every
// segment free before the first request is taken.
// An allocate request scans the map one segment per cycle from index 0 to
// find the lowest fitting run, then marks the run used and answers. An
// allocate that finds no fitting run answers once the scan reaches the last
// segment. A release marks each released segment free and then answers. A
// bad request or an oversized allocate answers without touching the map. The
// single memory read port sets the scan rate.
// ----------------------------------------------------------------------------
// Bitmap run allocator
// First-fit allocator of contiguous segment runs over a bit-serial free map.
// ----------------------------------------------------------------------------
module bitmap_run_allocator #(
	parameter int SEGMENTS = bra_pkg::SEGMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// Bits from the lowest: segment_index, segment_count, zero fill.
	input  logic [bra_pkg::S_DATA_W-1:0]  s_tdata,
	// Bits from the lowest: cmd.
	input  logic [bra_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Bits from the lowest: status, start_index, zero fill.
	output logic [bra_pkg::M_DATA_W-1:0]  m_tdata
);

	import bra_pkg::*;

	localparam int AW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int SW0 = $clog2(SEGMENTS + 1);
	localparam int SW  = (SW0 > 10) ? SW0 : 10;
	localparam logic [SW-1:0] SEG_N    = SW'(SEGMENTS);
	localparam logic [AW-1:0] SEG_LAST = AW'(SEGMENTS - 1);

	typedef enum logic [4:0] {
		CLEAR = 5'b00001,
		IDLE  = 5'b00010,
		SCAN  = 5'b00100,
		FILL  = 5'b01000,
		RESP  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [SW-1:0]        cnt_q;
	logic [SW-1:0]        remain_q;
	logic [AW-1:0]        wr_addr_q;
	logic                 fill_val_q;
	logic [SW-1:0]        issue_q;
	logic                 pend_q;
	logic [AW-1:0]        chk_q;
	logic [SW-1:0]        run_len_q;
	logic [AW-1:0]        run_start_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [START_W-1:0]   res_start_q;
	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;

	logic                 ram_we;
	logic                 ram_re;
	logic                 ram_rdata;
	logic [SW-1:0]        cnt_in;
	logic [SW-1:0]        idx_in;
	logic [SW-1:0]        run_len_inc;
	logic [AW-1:0]        start_nxt;

	assign cnt_in      = SW'(s_tdata[IDX_W+CNT_W-1:IDX_W]);
	assign idx_in      = SW'(s_tdata[IDX_W-1:0]);
	assign run_len_inc = run_len_q + SW'(1);
	assign start_nxt   = (run_len_q == '0) ? chk_q : run_start_q;

	assign ram_we   = (state_q == CLEAR) || (state_q == FILL);
	assign ram_re   = (state_q == SCAN) && (issue_q < SEG_N);
	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	bra_ram #(
		.WIDTH (1),
		.DEPTH (SEGMENTS),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr_q),
		.wdata (fill_val_q),
		.re    (ram_re),
		.raddr (issue_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CLEAR;
			cnt_q        <= '0;
			remain_q     <= SEG_N;
			wr_addr_q    <= '0;
			fill_val_q   <= 1'b1;
			issue_q      <= '0;
			pend_q       <= 1'b0;
			chk_q        <= '0;
			run_len_q    <= '0;
			run_start_q  <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					wr_addr_q <= wr_addr_q + AW'(1);
					remain_q  <= remain_q - SW'(1);
					if (remain_q == SW'(1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (s_tvalid) begin
						cnt_q        <= cnt_in;
						res_start_q  <= '0;
						res_status_q <= ST_OK;
						issue_q      <= '0;
						pend_q       <= 1'b0;
						run_len_q    <= '0;
						priority if (cnt_in == '0) begin
							res_status_q <= ST_BAD;
							state_q      <= RESP;
						end else if (s_tuser[0] == CMD_ALLOC) begin
							if (cnt_in > SEG_N) begin
								res_status_q <= ST_NOSPACE;
								state_q      <= RESP;
							end else begin
								state_q <= SCAN;
							end
						end else if (idx_in + cnt_in > SEG_N) begin
							res_status_q <= ST_BAD;
							state_q      <= RESP;
						end else begin
							wr_addr_q  <= idx_in[AW-1:0];
							remain_q   <= cnt_in;
							fill_val_q <= 1'b1;
							state_q    <= FILL;
						end
					end
				end
				SCAN: begin
					pend_q <= ram_re;
					chk_q  <= issue_q[AW-1:0];
					if (ram_re) begin
						issue_q <= issue_q + SW'(1);
					end
					if (pend_q) begin
						priority if (ram_rdata && (run_len_inc == cnt_q)) begin
							wr_addr_q   <= start_nxt;
							remain_q    <= cnt_q;
							fill_val_q  <= 1'b0;
							res_start_q <= START_W'(SW'(start_nxt));
							state_q     <= FILL;
						end else if (chk_q == SEG_LAST) begin
							res_status_q <= ST_NOSPACE;
							state_q      <= RESP;
						end else if (ram_rdata) begin
							run_len_q   <= run_len_inc;
							run_start_q <= start_nxt;
						end else begin
							run_len_q <= '0;
						end
					end
				end
				FILL: begin
					wr_addr_q <= wr_addr_q + AW'(1);
					remain_q  <= remain_q - SW'(1);
					if (remain_q == SW'(1)) begin
						state_q <= RESP;
					end
				end
				RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_DATA_W'({res_start_q, res_status_q});
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/bra_checker.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator checker
// Port-level assertions on the allocator, bound to its top level.
// ----------------------------------------------------------------------------
module bra_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [bra_pkg::S_DATA_W-1:0]  s_tdata,
	input logic [bra_pkg::S_USER_W-1:0]  s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bra_pkg::M_DATA_W-1:0]  m_tdata
);

	import bra_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("Request changed or dropped while waiting.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result changed or dropped while stalled.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[STATUS_W-1:0] == ST_OK) ||
			(m_tdata[STATUS_W-1:0] == ST_NOSPACE) ||
			(m_tdata[STATUS_W-1:0] == ST_BAD))
		else $error("Result carries an undefined status.");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK) |->
			m_tdata[STATUS_W+START_W-1:STATUS_W] == '0)
		else $error("Failed request returned a nonzero start.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input taken while a request was in progress.");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);
